// File: sv/tkv_pkg.sv
// Package for the timestamped key-value table.
// Holds table size, widths, status codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package tkv_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] ST_WRITE_DONE = 2'd0;
    localparam logic [1:0] ST_READ_HIT   = 2'd1;
    localparam logic [1:0] ST_READ_MISS  = 2'd2;
    localparam logic [1:0] ST_WRITE_DROP = 2'd3;

    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic load;
        logic read;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last;
    } t_stat;

endpackage

`default_nettype wire

// File: sv/tkv_ctrl.sv
// Controller for the timestamped key-value table.
// Sequences load, table scan, drain and finish; depends on tkv_pkg.
`default_nettype none

module tkv_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           start,
    output logic          busy,
    input  tkv_pkg::t_stat i_stat,
    output tkv_pkg::t_cmd  o_cmd
);
    import tkv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.read   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.empty ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.read = 1'b1;
                if (i_stat.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: sv/tkv_dp.sv
// Datapath for the timestamped key-value table.
// Holds the entry memory, fill count, scan compare and result register; uses tkv_pkg.
`default_nettype none

module tkv_dp (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  tkv_pkg::t_cmd               i_cmd,
    output tkv_pkg::t_stat              o_stat,
    input  wire                         i_mode,
    input  wire signed [tkv_pkg::DATA_W-1:0] i_key,
    input  wire signed [tkv_pkg::DATA_W-1:0] i_value,
    input  wire signed [tkv_pkg::DATA_W-1:0] i_timestamp,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic signed [tkv_pkg::DATA_W-1:0] o_read_value
);
    import tkv_pkg::*;

    t_entry r_mem [DEPTH];

    logic              r_mode;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_ts;

    logic [CNT_W-1:0]  r_fill;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_vld;
    t_entry            r_rd;

    logic              r_found;
    logic [ADDR_W-1:0] r_found_idx;
    logic              r_hit;
    logic [DATA_W-1:0] r_best_ts;
    logic [DATA_W-1:0] r_best_val;

    logic              r_valid;
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_rdata;

    logic              key_eq;
    logic              ts_eq;
    logic              ts_le_q;
    logic              best_le;
    logic              full;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    assign key_eq  = (r_rd.key == r_key);
    assign ts_eq   = (r_rd.stamp == r_ts);
    assign ts_le_q = ($signed(r_rd.stamp) <= $signed(r_ts));
    assign best_le = ($signed(r_best_ts) <= $signed(r_rd.stamp));
    assign full    = (r_fill == CNT_W'(DEPTH));

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.last  = (CNT_W'(r_addr) == (r_fill - CNT_W'(1)));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_found_idx;
        if (i_cmd.finish && (r_mode == MODE_STORE)) begin
            if (r_found) begin
                wr_en = 1'b1;
            end else if (!full) begin
                wr_en   = 1'b1;
                wr_addr = r_fill[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= '{key: r_key, stamp: r_ts, value: r_val};
        end
        if (i_cmd.read) begin
            r_rd      <= r_mem[r_addr];
            r_rd_addr <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_val  <= i_value;
            r_ts   <= i_timestamp;
        end
        if (i_cmd.load) begin
            r_addr <= '0;
        end else if (i_cmd.read) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        if (r_rd_vld && (r_mode == MODE_STORE) && !r_found && key_eq && ts_eq) begin
            r_found_idx <= r_rd_addr;
        end
        if (r_rd_vld && (r_mode == MODE_READ) && key_eq && ts_le_q && (!r_hit || best_le)) begin
            r_best_ts  <= r_rd.stamp;
            r_best_val <= r_rd.value;
        end
        if (i_cmd.finish) begin
            if (r_mode == MODE_STORE) begin
                r_status <= (r_found || !full) ? ST_WRITE_DONE : ST_WRITE_DROP;
                r_rdata  <= '0;
            end else if (r_hit) begin
                r_status <= ST_READ_HIT;
                r_rdata  <= r_best_val;
            end else begin
                r_status <= ST_READ_MISS;
                r_rdata  <= '1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_hit    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.read;
            r_valid  <= i_cmd.finish;
            if (i_cmd.load) begin
                r_found <= 1'b0;
                r_hit   <= 1'b0;
            end else if (r_rd_vld) begin
                if ((r_mode == MODE_STORE) && key_eq && ts_eq) begin
                    r_found <= 1'b1;
                end
                if ((r_mode == MODE_READ) && key_eq && ts_le_q) begin
                    r_hit <= 1'b1;
                end
            end
            if (wr_en && !r_found) begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rdata;

endmodule

`default_nettype wire

// File: sv/timestamped_key_value_table.sv
// After the start transfer the controller scans the stored entries (fill, 0 to 64), one
// memory read per cycle, then passes the drain and finish states; an empty table skips to finish.
// o_valid is registered from finish. One operation is taken at a time; busy holds until
// the result. The result is shown for one cycle on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) empties the table; entries are freed only by reset.
// Top level of the timestamped key-value table; instantiates tkv_ctrl and tkv_dp.
`default_nettype none

module timestamped_key_value_table (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_mode,
    input  wire signed [tkv_pkg::DATA_W-1:0] i_key,
    input  wire signed [tkv_pkg::DATA_W-1:0] i_value,
    input  wire signed [tkv_pkg::DATA_W-1:0] i_timestamp,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic signed [tkv_pkg::DATA_W-1:0] o_read_value
);
    import tkv_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tkv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tkv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_timestamp  (i_timestamp),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value)
    );

endmodule

`default_nettype wire

// File: sv/tkv_checker.sv
// Port-level checker for the timestamped key-value table, bound to the top level.
// Depends on tkv_pkg for status codes.
`default_nettype none

module tkv_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              start,
    input wire                              busy,
    input wire                              o_valid,
    input wire [1:0]                        o_status,
    input wire [tkv_pkg::DATA_W-1:0]        o_read_value
);
    import tkv_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start transfer");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_WRITE_DONE || o_status == ST_WRITE_DROP))
            |-> (o_read_value == '0))
        else $error("write result carries nonzero value");

    a_miss_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_READ_MISS)) |-> (o_read_value == '1))
        else $error("read miss value not all ones");

endmodule

bind timestamped_key_value_table tkv_checker u_tkv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_read_value (o_read_value)
);

`default_nettype wire

// File: verif/tb_timestamped_key_value_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for timestamped_key_value_table: stores and time-bounded lookups
// are predicted by a local copy of the table and compared field by field. Depends on tkv_pkg.

module tb_timestamped_key_value_table;
    import tkv_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] stamp;
    } t_kv_op;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] value;
    } t_kv_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              i_mode = MODE_STORE;
    logic [DATA_W-1:0] i_key = '0;
    logic [DATA_W-1:0] i_value = '0;
    logic [DATA_W-1:0] i_timestamp = '0;
    logic              busy;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [DATA_W-1:0] o_read_value;

    t_kv_op    pending_ops[$];
    t_kv_reply expected_replies[$];
    int        send_idle_pct = 0;
    int        mismatch_count = 0;
    int        cycle_count = 0;

    logic              kv_used[DEPTH] = '{default: 1'b0};
    logic [DATA_W-1:0] kv_key[DEPTH];
    logic [DATA_W-1:0] kv_stamp[DEPTH];
    logic [DATA_W-1:0] kv_data[DEPTH];

    logic [DATA_W-1:0] key_pool[8];
    logic [DATA_W-1:0] stamp_pool[12];

    timestamped_key_value_table i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_timestamp  (i_timestamp),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value)
    );

    always #10ns i_clk = ~i_clk;

    function automatic t_kv_reply kv_apply(t_kv_op op);
        t_kv_reply         r;
        logic              found;
        logic              have_free;
        logic              hit;
        int                free_idx;
        logic [DATA_W-1:0] best_stamp;
        r = '0;
        found = 1'b0;
        have_free = 1'b0;
        hit = 1'b0;
        free_idx = 0;
        best_stamp = '0;
        if (op.mode == MODE_STORE) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (kv_used[i]) begin
                    if (!found && kv_key[i] == op.key && kv_stamp[i] == op.stamp) begin
                        kv_data[i] = op.value;
                        found = 1'b1;
                    end
                end else if (!have_free) begin
                    have_free = 1'b1;
                    free_idx = i;
                end
            end
            r.status = ST_WRITE_DONE;
            if (!found && have_free) begin
                kv_used[free_idx] = 1'b1;
                kv_key[free_idx] = op.key;
                kv_stamp[free_idx] = op.stamp;
                kv_data[free_idx] = op.value;
            end else if (!found) begin
                r.status = ST_WRITE_DROP;
            end
        end else begin
            r.status = ST_READ_MISS;
            r.value = MISS_VALUE;
            for (int i = 0; i < DEPTH; i++) begin
                if (kv_used[i] && kv_key[i] == op.key
                        && $signed(kv_stamp[i]) <= $signed(op.stamp)) begin
                    if (!hit || $signed(best_stamp) <= $signed(kv_stamp[i])) begin
                        hit = 1'b1;
                        best_stamp = kv_stamp[i];
                        r.status = ST_READ_HIT;
                        r.value = kv_data[i];
                    end
                end
            end
        end
        return r;
    endfunction

    // driver: hold start until the transfer, then advance or idle
    always @(posedge i_clk) begin
        logic   accepted;
        logic   go;
        t_kv_op op;
        accepted = 1'b0;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                accepted = 1'b1;
                op = pending_ops.pop_front();
                expected_replies.push_back(kv_apply(op));
            end
            if (!start || accepted) begin
                go = pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
                if (go) begin
                    op = pending_ops[0];
                    i_mode <= op.mode;
                    i_key <= op.key;
                    i_value <= op.value;
                    i_timestamp <= op.stamp;
                end
                start <= go;
            end
        end
    end

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_kv_reply want;
        if (i_rst_n && o_valid) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected result, status", DATA_W'(o_status), '0);
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
                if (o_read_value !== want.value)
                    report_mismatch("read_value", o_read_value, want.value);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_op(logic mode, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value,
                           logic [DATA_W-1:0] stamp);
        t_kv_op op;
        op.mode = mode;
        op.key = key;
        op.value = value;
        op.stamp = stamp;
        pending_ops.push_back(op);
    endtask

    task automatic add_random(int count);
        int                pick;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] stamp;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, 7)];
            stamp = stamp_pool[$urandom_range(0, 11)];
            if (pick < 40) begin
                push_op(MODE_STORE, key, $urandom, stamp);
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0: stamp = stamp;
                    1: stamp = stamp + 1;
                    2: stamp = stamp - 1;
                    default: stamp = $urandom;
                endcase
                push_op(MODE_READ, key, $urandom, stamp);
            end else begin
                push_op(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_replies.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < 8; i++)
            key_pool[i] = $urandom;
        stamp_pool[0] = 32'h8000_0000;
        stamp_pool[1] = 32'h7fff_ffff;
        stamp_pool[2] = '1;
        stamp_pool[3] = '0;
        stamp_pool[4] = 32'd1;
        for (int i = 5; i < 9; i++)
            stamp_pool[i] = $urandom_range(0, 200) - 100;
        for (int i = 9; i < 12; i++)
            stamp_pool[i] = $urandom;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_op(MODE_READ, '0, $urandom, '0);
        push_op(MODE_STORE, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        push_op(MODE_STORE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_op(MODE_STORE, '1, '1, '1);
        push_op(MODE_STORE, '0, '0, '0);
        push_op(MODE_READ, 32'h8000_0000, '0, 32'h7fff_ffff);
        push_op(MODE_READ, 32'h8000_0000, '1, 32'h8000_0000);
        push_op(MODE_READ, 32'h7fff_ffff, '0, 32'h7fff_fffe);
        push_op(MODE_READ, '1, '0, '1);
        push_op(MODE_STORE, 32'd5, 32'd1, -32'sd10);
        push_op(MODE_STORE, 32'd5, 32'd2, 32'd10);
        push_op(MODE_STORE, 32'd5, 32'd3, 32'd3);
        push_op(MODE_READ, 32'd5, '0, -32'sd11);
        push_op(MODE_READ, 32'd5, '0, -32'sd10);
        push_op(MODE_READ, 32'd5, '0, '0);
        push_op(MODE_READ, 32'd5, '0, 32'd5);
        push_op(MODE_READ, 32'd5, '0, 32'd100);
        push_op(MODE_STORE, 32'd5, 32'd4, 32'd10);
        push_op(MODE_READ, 32'd5, '1, 32'd10);
        push_op(MODE_READ, 32'd6, '0, '0);
        // fill the table with fresh pairs, then hit it when full
        for (int i = 0; i < DEPTH; i++)
            push_op(MODE_STORE, 32'hA5A5_0000 + i, $urandom, i);
        push_op(MODE_STORE, 32'hA5A5_0000, 32'd77, '0);
        push_op(MODE_READ, 32'hA5A5_0000, '0, '1);

        send_idle_pct = 0;
        add_random(550);
        wait_drained();
        send_idle_pct = 80;
        add_random(500);
        wait_drained();
        send_idle_pct = 18;
        add_random(500);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/tkv_pkg.sv
sv/tkv_ctrl.sv
sv/tkv_dp.sv
sv/timestamped_key_value_table.sv
sv/tkv_checker.sv
verif/tb_timestamped_key_value_table.sv
